@@ rtl/cftrk_pkg.sv @@
// Shared types and constants for the coverage-to-fixedStep track encoder.
// Used by the register block, controller, datapath and top level.
`default_nettype none

package cftrk_pkg;

  // Fixed field widths
  localparam int POS_BITS   = 31;
  localparam int DEPTH_BITS = 24;
  localparam int GAP_BITS   = 6;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 4;
  localparam int WPOS_BITS  = 32;

  // Register reset values
  localparam logic [POS_BITS-1:0] REGION_BEGIN_RESET = 31'd0;
  localparam logic [POS_BITS-1:0] REGION_END_RESET   = 31'h7FFF_FFFF;
  localparam logic [GAP_BITS-1:0] GAP_RESET          = 6'd10;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_REGION_BEGIN = 2'd0;
  localparam logic [1:0] REG_REGION_END   = 2'd1;
  localparam logic [1:0] REG_MAX_ZERO_GAP = 2'd2;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic zero_upd;
    logic emit_hdr;
    logic emit_fill;
    logic emit_val;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_region;
    logic depth_zero;
    logic fresh;
    logic zc_zero;
    logic zc_one;
    logic slot_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/coverage_to_fixedstep_track.sv @@
// Top level of the coverage-to-fixedStep track encoder.
// Instantiates cftrk_regs, cftrk_ctrl and cftrk_dp; uses cftrk_pkg.
//
// Each accepted item is a per-position coverage record; records outside
// [region_begin, region_end) give nothing, zero depths extend a pending gap,
// and a nonzero depth gives an optional segment header (1-based start), the
// pending zero filler lines and its value line, with last set on the value.
// An item is accepted in the idle state and classified, with its first result
// if any, in the evaluate state; every result waits for a free output slot, so
// an item is held longer while out_ready is low. Within one item the result
// register takes one result per cycle while out_ready is high; a new input item is
// taken while the final result of the previous one still waits in that register.
`default_nettype none

module coverage_to_fixedstep_track #(
  parameter int CHROM_ID_BITS = 16,
  parameter int MAX_GAP_LIMIT = 63
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [CHROM_ID_BITS-1:0]         in_chrom_id,
  input  wire logic [cftrk_pkg::POS_BITS-1:0]   in_position,
  input  wire logic [cftrk_pkg::DEPTH_BITS-1:0] in_depth,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic      [CHROM_ID_BITS-1:0]         out_chrom_id_out,
  output logic      [cftrk_pkg::POS_BITS-1:0]   out_start_pos,
  output logic      [cftrk_pkg::DEPTH_BITS-1:0] out_value,
  output logic                                  out_last,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cftrk_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [cftrk_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [cftrk_pkg::DATA_BITS-1:0]  prdata,
  output logic                                  pready
);

  logic [cftrk_pkg::POS_BITS-1:0] region_begin;
  logic [cftrk_pkg::POS_BITS-1:0] region_end;
  logic [cftrk_pkg::GAP_BITS-1:0] max_zero_gap;
  cftrk_pkg::cmd_t                cmd;
  cftrk_pkg::sts_t                sts;

  // Configuration registers
  cftrk_regs #(
    .MAX_GAP_LIMIT(MAX_GAP_LIMIT)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .region_begin(region_begin),
    .region_end  (region_end),
    .max_zero_gap(max_zero_gap)
  );

  // Sequencer
  cftrk_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Datapath
  cftrk_dp #(
    .CHROM_ID_BITS(CHROM_ID_BITS),
    .MAX_GAP_LIMIT(MAX_GAP_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_chrom_id     (in_chrom_id),
    .in_position     (in_position),
    .in_depth        (in_depth),
    .region_begin    (region_begin),
    .region_end      (region_end),
    .max_zero_gap    (max_zero_gap),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_chrom_id_out(out_chrom_id_out),
    .out_start_pos   (out_start_pos),
    .out_value       (out_value),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/cftrk_regs.sv @@
// Configuration registers behind the APB-style port.
// Uses cftrk_pkg for widths, indexes and reset values.
`default_nettype none

module cftrk_regs #(
  parameter int MAX_GAP_LIMIT = 63
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cftrk_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [cftrk_pkg::DATA_BITS-1:0] pwdata,
  output logic      [cftrk_pkg::DATA_BITS-1:0] prdata,
  output logic                                 pready,
  output logic      [cftrk_pkg::POS_BITS-1:0]  region_begin,
  output logic      [cftrk_pkg::POS_BITS-1:0]  region_end,
  output logic      [cftrk_pkg::GAP_BITS-1:0]  max_zero_gap
);

  logic [cftrk_pkg::POS_BITS-1:0] begin_r, begin_nxt;
  logic [cftrk_pkg::POS_BITS-1:0] end_r, end_nxt;
  logic [cftrk_pkg::GAP_BITS-1:0] gap_r, gap_nxt;
  logic [cftrk_pkg::GAP_BITS-1:0] gap_wr;
  logic [1:0]                     idx;
  logic                           wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Clamp the gap setting to the built-in limit
  always_comb begin
    if (int'(pwdata[cftrk_pkg::GAP_BITS-1:0]) > MAX_GAP_LIMIT) begin
      gap_wr = cftrk_pkg::GAP_BITS'(MAX_GAP_LIMIT);
    end else begin
      gap_wr = pwdata[cftrk_pkg::GAP_BITS-1:0];
    end
  end

  // Decode writes
  always_comb begin
    begin_nxt = begin_r;
    end_nxt   = end_r;
    gap_nxt   = gap_r;
    if (wr_en) begin
      case (idx)
        cftrk_pkg::REG_REGION_BEGIN: begin_nxt = pwdata[cftrk_pkg::POS_BITS-1:0];
        cftrk_pkg::REG_REGION_END:   end_nxt   = pwdata[cftrk_pkg::POS_BITS-1:0];
        cftrk_pkg::REG_MAX_ZERO_GAP: gap_nxt   = gap_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_r <= cftrk_pkg::REGION_BEGIN_RESET;
      end_r   <= cftrk_pkg::REGION_END_RESET;
      gap_r   <= cftrk_pkg::GAP_RESET;
    end else begin
      begin_r <= begin_nxt;
      end_r   <= end_nxt;
      gap_r   <= gap_nxt;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      cftrk_pkg::REG_REGION_BEGIN: prdata = cftrk_pkg::DATA_BITS'(begin_r);
      cftrk_pkg::REG_REGION_END:   prdata = cftrk_pkg::DATA_BITS'(end_r);
      cftrk_pkg::REG_MAX_ZERO_GAP: prdata = cftrk_pkg::DATA_BITS'(gap_r);
      default:                     prdata = '0;
    endcase
  end

  assign region_begin = begin_r;
  assign region_end   = end_r;
  assign max_zero_gap = gap_r;

endmodule

`default_nettype wire

@@ rtl/cftrk_ctrl.sv @@
// Controller state machine: sequences accept, classify and emission steps.
// Uses cftrk_pkg command and status structs; drives the datapath.
`default_nettype none

module cftrk_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cftrk_pkg::sts_t sts,
  output cftrk_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;
  localparam logic [1:0] S_VAL  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.in_region) begin
          state_nxt = S_IDLE;
        end else if (sts.depth_zero) begin
          cmd.zero_upd = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.slot_free) begin
          if (sts.fresh) begin
            cmd.emit_hdr = 1'b1;
            state_nxt    = S_VAL;
          end else if (sts.zc_zero) begin
            cmd.emit_val = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.emit_fill = 1'b1;
            state_nxt     = sts.zc_one ? S_VAL : S_FILL;
          end
        end
      end
      S_FILL: begin
        if (sts.slot_free) begin
          cmd.emit_fill = 1'b1;
          if (sts.zc_one) begin
            state_nxt = S_VAL;
          end
        end
      end
      S_VAL: begin
        if (sts.slot_free) begin
          cmd.emit_val = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cftrk_dp.sv @@
// Datapath: input latch, segment tracking state, gap counter, output register.
// Uses cftrk_pkg command and status structs; commanded by cftrk_ctrl.
`default_nettype none

module cftrk_dp #(
  parameter int CHROM_ID_BITS = 16,
  parameter int MAX_GAP_LIMIT = 63
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cftrk_pkg::cmd_t                  cmd,
  output cftrk_pkg::sts_t                       sts,
  input  wire logic [CHROM_ID_BITS-1:0]         in_chrom_id,
  input  wire logic [cftrk_pkg::POS_BITS-1:0]   in_position,
  input  wire logic [cftrk_pkg::DEPTH_BITS-1:0] in_depth,
  input  wire logic [cftrk_pkg::POS_BITS-1:0]   region_begin,
  input  wire logic [cftrk_pkg::POS_BITS-1:0]   region_end,
  input  wire logic [cftrk_pkg::GAP_BITS-1:0]   max_zero_gap,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic      [CHROM_ID_BITS-1:0]         out_chrom_id_out,
  output logic      [cftrk_pkg::POS_BITS-1:0]   out_start_pos,
  output logic      [cftrk_pkg::DEPTH_BITS-1:0] out_value,
  output logic                                  out_last
);

  localparam int ZC_BITS = $clog2(MAX_GAP_LIMIT + 2);
  localparam logic [ZC_BITS-1:0] ZC_SAT = ZC_BITS'(MAX_GAP_LIMIT + 1);
  localparam logic [ZC_BITS-1:0] ZC_ONE = ZC_BITS'(1);

  // Latched input item
  logic [CHROM_ID_BITS-1:0]         chrom_r, chrom_nxt;
  logic [cftrk_pkg::POS_BITS-1:0]   pos_r, pos_nxt;
  logic [cftrk_pkg::DEPTH_BITS-1:0] depth_r, depth_nxt;

  // Segment tracking state
  logic [CHROM_ID_BITS:0]          prev_chrom_r, prev_chrom_nxt;
  logic [cftrk_pkg::WPOS_BITS-1:0] prev_pos_r, prev_pos_nxt;
  logic [ZC_BITS-1:0]              zc_r, zc_nxt;

  // Output register
  logic                             ovalid_r, ovalid_nxt;
  logic                             okind_r, okind_nxt;
  logic [CHROM_ID_BITS-1:0]         ochrom_r, ochrom_nxt;
  logic [cftrk_pkg::POS_BITS-1:0]   ostart_r, ostart_nxt;
  logic [cftrk_pkg::DEPTH_BITS-1:0] ovalue_r, ovalue_nxt;
  logic                             olast_r, olast_nxt;

  logic [cftrk_pkg::WPOS_BITS-1:0] expected;
  logic                            emit;

  // Classify the latched item
  assign expected = prev_pos_r + cftrk_pkg::WPOS_BITS'(zc_r) + cftrk_pkg::WPOS_BITS'(1);

  always_comb begin
    sts.in_region  = (pos_r >= region_begin) && (pos_r < region_end);
    sts.depth_zero = (depth_r == '0);
    sts.fresh      = ({1'b0, chrom_r} != prev_chrom_r) ||
                     (expected != {1'b0, pos_r}) ||
                     (32'(zc_r) > 32'(max_zero_gap));
    sts.zc_zero    = (zc_r == '0);
    sts.zc_one     = (zc_r == ZC_ONE);
    sts.slot_free  = !ovalid_r || out_ready;
  end

  // Capture the input item
  always_comb begin
    chrom_nxt = chrom_r;
    pos_nxt   = pos_r;
    depth_nxt = depth_r;
    if (cmd.load_in) begin
      chrom_nxt = in_chrom_id;
      pos_nxt   = in_position;
      depth_nxt = in_depth;
    end
  end

  // Update tracking state
  always_comb begin
    prev_chrom_nxt = prev_chrom_r;
    prev_pos_nxt   = prev_pos_r;
    zc_nxt         = zc_r;
    if (cmd.zero_upd) begin
      prev_chrom_nxt = {1'b0, chrom_r};
      if (zc_r != ZC_SAT) begin
        zc_nxt = zc_r + ZC_ONE;
      end
    end
    if (cmd.emit_hdr) begin
      zc_nxt = '0;
    end
    if (cmd.emit_fill) begin
      zc_nxt = zc_r - ZC_ONE;
    end
    if (cmd.emit_val) begin
      prev_chrom_nxt = {1'b0, chrom_r};
      prev_pos_nxt   = {1'b0, pos_r};
    end
  end

  // Load the output register with the next result
  assign emit = cmd.emit_hdr || cmd.emit_fill || cmd.emit_val;

  always_comb begin
    ovalid_nxt = ovalid_r && !out_ready;
    okind_nxt  = okind_r;
    ochrom_nxt = ochrom_r;
    ostart_nxt = ostart_r;
    ovalue_nxt = ovalue_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      okind_nxt  = cmd.emit_hdr ? cftrk_pkg::KIND_HEADER : cftrk_pkg::KIND_VALUE;
      ochrom_nxt = cmd.emit_hdr ? chrom_r : '0;
      ostart_nxt = cmd.emit_hdr ? pos_r + cftrk_pkg::POS_BITS'(1) : '0;
      ovalue_nxt = cmd.emit_val ? depth_r : '0;
      olast_nxt  = cmd.emit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_chrom_r <= '1;
      prev_pos_r   <= '1;
      zc_r         <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      prev_chrom_r <= prev_chrom_nxt;
      prev_pos_r   <= prev_pos_nxt;
      zc_r         <= zc_nxt;
      ovalid_r     <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chrom_r  <= chrom_nxt;
    pos_r    <= pos_nxt;
    depth_r  <= depth_nxt;
    okind_r  <= okind_nxt;
    ochrom_r <= ochrom_nxt;
    ostart_r <= ostart_nxt;
    ovalue_r <= ovalue_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_kind         = okind_r;
  assign out_chrom_id_out = ochrom_r;
  assign out_start_pos    = ostart_r;
  assign out_value        = ovalue_r;
  assign out_last         = olast_r;

endmodule

`default_nettype wire

@@ tb/cftrk_track_checker.sv @@
// Checker for the coverage-to-fixedStep track encoder: watches the record,
// track line and register ports, predicts every line and compares in order.
// Depends on cftrk_pkg for field widths, register indexes and line kinds.
module cftrk_track_checker #(
  parameter int CHROM_BITS = 16,
  parameter int GAP_CAP    = 63
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire logic [CHROM_BITS-1:0]            in_chrom_id,
  input  wire logic [cftrk_pkg::POS_BITS-1:0]   in_position,
  input  wire logic [cftrk_pkg::DEPTH_BITS-1:0] in_depth,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic                             out_kind,
  input  wire logic [CHROM_BITS-1:0]            out_chrom_id_out,
  input  wire logic [cftrk_pkg::POS_BITS-1:0]   out_start_pos,
  input  wire logic [cftrk_pkg::DEPTH_BITS-1:0] out_value,
  input  wire logic                             out_last,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic                             pready,
  input  wire logic [cftrk_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [cftrk_pkg::DATA_BITS-1:0]  pwdata,
  output int                                    lines_owed,
  output int                                    mismatch_count
);
  import cftrk_pkg::*;

  typedef struct packed {
    logic                  kind;
    logic [CHROM_BITS-1:0] chrom;
    logic [POS_BITS-1:0]   start;
    logic [DEPTH_BITS-1:0] value;
    logic                  last;
  } track_line_t;

  track_line_t track_lines[$];
  track_line_t seen;
  track_line_t want;

  // Register copy, taken from observed writes
  logic [POS_BITS-1:0]  lo_bound;
  logic [POS_BITS-1:0]  hi_bound;
  logic [GAP_BITS-1:0]  gap_limit;

  // Encoder state
  logic [CHROM_BITS:0]  last_chrom;
  logic [WPOS_BITS-1:0] last_pos;
  int                   zero_run;
  int                   fails = 0;

  function automatic void push_line(input logic kind, input logic [CHROM_BITS-1:0] chrom,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [DEPTH_BITS-1:0] value, input logic last);
    track_line_t line;
    line.kind  = kind;
    line.chrom = chrom;
    line.start = start;
    line.value = value;
    line.last  = last;
    track_lines.push_back(line);
  endfunction

  // Work out the track lines caused by one coverage record
  function automatic void encode_record(input logic [CHROM_BITS-1:0] chrom,
                                        input logic [POS_BITS-1:0] pos,
                                        input logic [DEPTH_BITS-1:0] depth);
    logic [WPOS_BITS-1:0] next_pos;
    int                   eff_gap;
    logic                 open_seg;
    if (pos < lo_bound || pos >= hi_bound) return;
    eff_gap = (int'(gap_limit) > GAP_CAP) ? GAP_CAP : int'(gap_limit);
    if (depth == '0) begin
      // zeros extend the pending gap (saturating one past the cap) and give no line
      if (zero_run < GAP_CAP + 1) zero_run++;
    end else begin
      next_pos = last_pos + 32'd1 + 32'(zero_run);
      open_seg = (last_chrom != {1'b0, chrom}) || (next_pos != {1'b0, pos}) ||
                 (zero_run > eff_gap);
      if (open_seg) begin
        zero_run = 0;
        push_line(KIND_HEADER, chrom, pos + 31'd1, '0, 1'b0);
      end
      while (zero_run > 0) begin
        push_line(KIND_VALUE, '0, '0, '0, 1'b0);
        zero_run--;
      end
      push_line(KIND_VALUE, '0, '0, depth, 1'b1);
      last_pos = {1'b0, pos};
    end
    last_chrom = {1'b0, chrom};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lo_bound   = REGION_BEGIN_RESET;
      hi_bound   = REGION_END_RESET;
      gap_limit  = GAP_RESET;
      last_chrom = '1;
      last_pos   = '1;
      zero_run   = 0;
      track_lines.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_REGION_BEGIN: lo_bound = pwdata[POS_BITS-1:0];
          REG_REGION_END:   hi_bound = pwdata[POS_BITS-1:0];
          REG_MAX_ZERO_GAP: gap_limit = pwdata[GAP_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) encode_record(in_chrom_id, in_position, in_depth);
      // Compare each accepted line with the oldest prediction
      if (out_valid && out_ready) begin
        seen.kind  = out_kind;
        seen.chrom = out_chrom_id_out;
        seen.start = out_start_pos;
        seen.value = out_value;
        seen.last  = out_last;
        if (track_lines.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected line: kind %0d chrom %0d start %0d value %0d last %0d",
                     seen.kind, seen.chrom, seen.start, seen.value, seen.last);
        end else begin
          want = track_lines.pop_front();
          if (seen.kind != want.kind || seen.chrom != want.chrom ||
              seen.start != want.start || seen.value != want.value ||
              seen.last != want.last) begin
            fails++;
            if (fails <= 10)
              $display("line mismatch: exp kind %0d chrom %0d start %0d value %0d last %0d",
                       want.kind, want.chrom, want.start, want.value, want.last,
                       " / got kind %0d chrom %0d start %0d value %0d last %0d",
                       seen.kind, seen.chrom, seen.start, seen.value, seen.last);
          end
        end
      end
    end
    lines_owed     <= track_lines.size();
    mismatch_count <= fails;
  end

endmodule

@@ tb/tb_coverage_to_fixedstep_track.sv @@
// Testbench top for the coverage-to-fixedStep track encoder: drives records,
// register writes and result backpressure, and reports the verdict.
// Depends on cftrk_pkg, coverage_to_fixedstep_track and cftrk_track_checker.
module tb_coverage_to_fixedstep_track;
  import cftrk_pkg::*;

  localparam int                  CHROM_BITS  = 16;
  localparam int                  GAP_CAP     = 63;
  localparam int                  HOLD_CYCLES = 300;
  localparam logic [POS_BITS-1:0] POS_TOP     = 31'h7FFF_FFFE;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [CHROM_BITS-1:0] in_chrom_id = '0;
  logic [POS_BITS-1:0]   in_position = '0;
  logic [DEPTH_BITS-1:0] in_depth    = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic                  out_kind;
  logic [CHROM_BITS-1:0] out_chrom_id_out;
  logic [POS_BITS-1:0]   out_start_pos;
  logic [DEPTH_BITS-1:0] out_value;
  logic                  out_last;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [ADDR_BITS-1:0]  paddr       = '0;
  logic [DATA_BITS-1:0]  pwdata      = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  int                    lines_owed;
  int                    mismatch_count;

  // Traffic shaping
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Generator's view of the registers and the running track
  logic [POS_BITS-1:0]   cur_lo    = REGION_BEGIN_RESET;
  logic [POS_BITS-1:0]   cur_hi    = REGION_END_RESET;
  logic [GAP_BITS-1:0]   cur_gap   = GAP_RESET;
  logic [CHROM_BITS-1:0] trk_chrom = '0;
  logic [31:0]           trk_next  = '0;
  int                    live_items = 0;

  coverage_to_fixedstep_track #(
    .CHROM_ID_BITS(CHROM_BITS),
    .MAX_GAP_LIMIT(GAP_CAP)
  ) dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_chrom_id, .in_position, .in_depth,
    .out_valid, .out_ready, .out_kind, .out_chrom_id_out, .out_start_pos,
    .out_value, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cftrk_track_checker #(
    .CHROM_BITS(CHROM_BITS),
    .GAP_CAP(GAP_CAP)
  ) u_chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_chrom_id, .in_position, .in_depth,
    .out_valid, .out_ready, .out_kind, .out_chrom_id_out, .out_start_pos,
    .out_value, .out_last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .lines_owed, .mismatch_count
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #(12 * 1_000_000);
    $display("Test completed with failures");
    $finish;
  end

  task automatic apply_mode(input int m);
    case (m)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 59; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 59; end
      default: begin idle_pct = 6; stall_pct <= 6; end
    endcase
  endtask

  // Offer one record and hold it until accepted; valid stays up afterwards
  task automatic feed(input logic [CHROM_BITS-1:0] c, input logic [31:0] p,
                      input logic [DEPTH_BITS-1:0] d);
    logic [POS_BITS-1:0] pos;
    pos = (p > 32'(POS_TOP)) ? POS_TOP : p[POS_BITS-1:0];
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_chrom_id <= c;
    in_position <= pos;
    in_depth    <= d;
    if (pos >= cur_lo && pos < cur_hi) live_items++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted line has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lines_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REGION_BEGIN: cur_lo = d[POS_BITS-1:0];
      REG_REGION_END:   cur_hi = d[POS_BITS-1:0];
      REG_MAX_ZERO_GAP: cur_gap = d[GAP_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] step_pos(input logic [31:0] p);
    return (p >= 32'(POS_TOP)) ? 32'd0 : p + 32'd1;
  endfunction

  function automatic logic [31:0] pick_pos();
    logic [31:0] span;
    span = 32'(cur_hi) - 32'(cur_lo);
    if (cur_hi <= cur_lo) return $urandom & 32'h7FFF_FFFF;
    return 32'(cur_lo) + ($urandom % span);
  endfunction

  function automatic logic [DEPTH_BITS-1:0] depth_val();
    logic [DEPTH_BITS-1:0] d;
    if ($urandom_range(99) < 60) d = DEPTH_BITS'($urandom_range(1, 255));
    else d = DEPTH_BITS'($urandom);
    if (d == '0) d = 1;
    return d;
  endfunction

  // Mostly short gaps, some right at the limit, a few near saturation
  function automatic int zero_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 90) return int'(cur_gap) + $urandom_range(1);
    return $urandom_range(60, 66);
  endfunction

  // Lay down a well-formed run: contiguous positions, nonzero depths, zero gaps
  task automatic lay_segment();
    logic [CHROM_BITS-1:0] c;
    logic [31:0]           p;
    int                    runs;
    int                    zeros;
    if ($urandom_range(1) == 1) begin
      c = trk_chrom;
      p = trk_next;
    end else begin
      c = ($urandom_range(3) == 0) ? CHROM_BITS'($urandom) : CHROM_BITS'($urandom_range(0, 7));
      p = pick_pos();
    end
    runs = $urandom_range(1, 10);
    repeat (runs) begin
      zeros = ($urandom_range(99) < 30) ? zero_len() : 0;
      repeat (zeros) begin
        feed(c, p, '0);
        p = step_pos(p);
      end
      feed(c, p, depth_val());
      p = step_pos(p);
    end
    trk_chrom = c;
    trk_next  = p;
  endtask

  // Mix well-formed runs with noise and broken continuations
  task automatic random_batch(input int n);
    int goal;
    int tries;
    int pick;
    goal  = live_items + n;
    tries = 0;
    while (live_items < goal && tries < 4 * n) begin
      apply_mode(((goal - live_items) / 20) % 4);
      pick = $urandom_range(99);
      if (pick < 70) begin
        lay_segment();
      end else if (pick < 85) begin
        feed(CHROM_BITS'($urandom), $urandom & 32'h7FFF_FFFF,
             ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom));
      end else begin
        feed(trk_chrom ^ CHROM_BITS'($urandom_range(1)), trk_next + $urandom_range(0, 3),
             depth_val());
      end
      tries++;
    end
  endtask

  initial begin
    logic [31:0] lo_pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: start after reset, extremes, chrom change by a zero record
    apply_mode(0);
    feed(5, 0, '0);
    feed(5, 1, '0);
    feed(5, 2, 7);
    feed(5, 3, 24'hFF_FFFF);
    feed(5, 5, 1);
    feed(0, 6, 9);
    feed(16'hFFFF, 7, 3);
    feed(16'hFFFF, 32'h7FFF_FFFE, 24'h80_0000);
    feed(16'hAAAA, 32'h2AAA_AAAA, 24'h55_5555);
    feed(16'h5555, 32'h5555_5555, 24'hAA_AAAA);
    feed(1, 100, 5);
    feed(2, 101, 0);
    feed(1, 102, 6);
    feed(1, 103, 0);
    feed(1, 104, 8);
    random_batch(60);

    // No gap tolerated: a single zero opens a new segment
    settle();
    cfg_write(REG_REGION_BEGIN, 32'd0);
    cfg_write(REG_REGION_END, 32'h7FFF_FFFF);
    cfg_write(REG_MAX_ZERO_GAP, 32'd0);
    feed(3, 10, 4);
    feed(3, 11, '0);
    feed(3, 12, 5);
    feed(3, 13, 6);
    random_batch(50);

    // Narrow region, widest gap: region edges and gap saturation
    settle();
    cfg_write(REG_REGION_BEGIN, 32'd1000);
    cfg_write(REG_REGION_END, 32'd5096);
    cfg_write(REG_MAX_ZERO_GAP, 32'd63);
    apply_mode(3);
    feed(9, 999, 5);
    feed(9, 5096, 5);
    feed(9, 5095, 5);
    feed(9, 1000, 3);
    for (int k = 1001; k <= 1063; k++) feed(9, k, '0);
    feed(9, 1064, 2);
    for (int k = 1065; k <= 1128; k++) feed(9, k, '0);
    feed(9, 1129, 4);
    random_batch(50);

    // Region at the top of the position range
    settle();
    cfg_write(REG_REGION_BEGIN, 32'h7FFF_FF00);
    cfg_write(REG_REGION_END, 32'h7FFF_FFFF);
    cfg_write(REG_MAX_ZERO_GAP, $urandom_range(0, 63));
    random_batch(40);

    // Empty region: everything is dropped
    settle();
    cfg_write(REG_REGION_BEGIN, 32'h7FFF_FFFF);
    cfg_write(REG_REGION_END, 32'd0);
    repeat (8) feed(CHROM_BITS'($urandom), $urandom & 32'h7FFF_FFFF, depth_val());

    // Long receiver hold while records keep coming
    settle();
    cfg_write(REG_REGION_BEGIN, 32'd0);
    cfg_write(REG_REGION_END, 32'h7FFF_FFFF);
    cfg_write(REG_MAX_ZERO_GAP, $urandom_range(0, 63));
    apply_mode(0);
    hold_reqs <= hold_reqs + 1;
    repeat (4) lay_segment();

    // Random settings
    settle();
    lo_pick = $urandom_range(0, 32'h4000_0000);
    cfg_write(REG_REGION_BEGIN, lo_pick);
    cfg_write(REG_REGION_END, lo_pick + $urandom_range(64, 1 << 20));
    cfg_write(REG_MAX_ZERO_GAP, $urandom_range(0, 63));
    random_batch(50);

    settle();
    if (mismatch_count == 0 && lines_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cftrk_pkg.sv
rtl/cftrk_regs.sv
rtl/cftrk_ctrl.sv
rtl/cftrk_dp.sv
rtl/coverage_to_fixedstep_track.sv
tb/cftrk_track_checker.sv
tb/tb_coverage_to_fixedstep_track.sv
